// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers shared by the RTL. Each macro takes a label, clock,
// active-low reset, antecedent, consequent and message; checks are
// disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/cmd_frm_pkg.sv
// ----------------------------------------------------------------------------
// cmd_frm_pkg
// Beat types, framing characters, checksum mode codes and the CRC-16 and
// hex helpers of the command framer.
// ----------------------------------------------------------------------------
`default_nettype none

package cmd_frm_pkg;

    // Input beat: one command character
    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_last;
    } t_in_beat;

    // Output beat: one sentence character
    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } t_out_beat;

    // Framing characters
    localparam logic [7:0] CHAR_START = 8'h24;   // '$'
    localparam logic [7:0] CHAR_STAR  = 8'h2A;   // '*'
    localparam logic [7:0] CHAR_NL    = 8'h0A;   // newline

    // Checksum modes (code 3 behaves as CRC)
    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_XOR  = 2'd1;
    localparam logic [1:0] MODE_CRC  = 2'd2;
    localparam logic [1:0] MODE_RESET = MODE_XOR;

    // CRC-16-CCITT, poly 0x1021, byte-wise XModem fold
    function automatic logic [15:0] crc_fold(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] x;
        x = {c[7:0], c[15:8]};
        x = x ^ {8'h00, b};
        x = x ^ {12'h000, x[7:4]};
        x = x ^ {x[3:0], 12'h000};
        x = x ^ {3'b000, x[7:0], 5'b00000};
        return x;
    endfunction

    // Upper-case hex character of a nibble
    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic [7:0] r;
        if (n < 4'd10) begin
            r = 8'h30 + {4'h0, n};
        end else begin
            r = 8'h37 + {4'h0, n};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hdl/command_framer_with_checksum_core.sv
// ----------------------------------------------------------------------------
// command_framer_with_checksum_core
// Frames command characters into '$'-led sentences with an optional XOR-8
// or CRC-16 hex checksum and a closing newline.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) carries one command
//   character per beat, is_last set on the final one. Output channel
//   (o_out_valid / i_out_stall / o_out_data) carries sentence characters,
//   out_last set on the closing newline.
//   i_cfg_we / i_cfg_data write the checksum mode (0 none, 1 XOR, 2 or 3
//   CRC); write it only while the framer is idle.
//   The first sentence character appears in the cycle after the input
//   beat is taken. A beat yields one to eight characters, one per cycle
//   while the receiver does not stall; the next input beat is taken in
//   the cycle its predecessor's final character leaves, so middle
//   characters stream at one per cycle unless the receiver stalls.
//   The slot register holds at most one beat's characters at a time.
//   Reset clears the sums, the sentence flag and the pending characters
//   and sets the mode to XOR. When the receiver stalls the current
//   character holds and the input stalls once the last pending character
//   is blocked.
// ----------------------------------------------------------------------------
`default_nettype none

module command_framer_with_checksum_core
    import cmd_frm_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    // configuration
    input  wire logic      i_cfg_we,
    input  wire logic [1:0] i_cfg_data,
    // command character input
    input  wire logic      i_in_valid,
    output      logic      o_in_stall,
    input  wire t_in_beat  i_in_data,
    // sentence output
    output      logic      o_out_valid,
    input  wire logic      i_out_stall,
    output      t_out_beat o_out_data
);

`include "assert_macros.svh"

    // Slot positions of the fixed sentence template
    localparam logic [2:0] SLOT_START = 3'd0;
    localparam logic [2:0] SLOT_DATA  = 3'd1;
    localparam logic [2:0] SLOT_STAR  = 3'd2;
    localparam logic [2:0] SLOT_D3    = 3'd3;
    localparam logic [2:0] SLOT_D2    = 3'd4;
    localparam logic [2:0] SLOT_D1    = 3'd5;
    localparam logic [2:0] SLOT_D0    = 3'd6;
    localparam logic [2:0] SLOT_NL    = 3'd7;

    logic [1:0]  r_mode;
    logic        r_in_sentence;
    logic [7:0]  r_xor;
    logic [15:0] r_crc;
    logic [7:0]  r_mask, n_mask;
    logic [7:0]  r_byte;
    logic [7:0]  r_dig [4];

    logic        in_acc, out_acc;
    logic [2:0]  sel;
    logic [7:0]  sel_bit;
    logic [7:0]  n_xor;
    logic [15:0] n_crc;
    logic [7:0]  n_dig [4];
    logic [7:0]  acc_mask;
    logic        is_crc;

    // Handshakes
    assign out_acc    = o_out_valid && !i_out_stall;
    assign o_in_stall = !((r_mask == 8'h00) || ($onehot(r_mask) && !i_out_stall));
    assign in_acc     = i_in_valid && !o_in_stall;

    // Lowest pending slot goes out first
    always_comb begin
        sel = SLOT_NL;
        for (int k = 7; k >= 0; k--) begin
            if (r_mask[k]) begin
                sel = 3'(k);
            end
        end
        sel_bit = 8'h01 << sel;
    end

    always_comb begin
        o_out_valid         = (r_mask != 8'h00);
        o_out_data.out_last = (sel == SLOT_NL);
        case (sel)
            SLOT_START: o_out_data.out_byte = CHAR_START;
            SLOT_DATA:  o_out_data.out_byte = r_byte;
            SLOT_STAR:  o_out_data.out_byte = CHAR_STAR;
            SLOT_D3:    o_out_data.out_byte = r_dig[0];
            SLOT_D2:    o_out_data.out_byte = r_dig[1];
            SLOT_D1:    o_out_data.out_byte = r_dig[2];
            SLOT_D0:    o_out_data.out_byte = r_dig[3];
            SLOT_NL:    o_out_data.out_byte = CHAR_NL;
            default:    o_out_data.out_byte = CHAR_NL;
        endcase
    end

    // Fold the incoming character and build its slot set
    always_comb begin
        n_xor  = r_xor ^ i_in_data.data_byte;
        n_crc  = crc_fold(r_crc, i_in_data.data_byte);
        is_crc = (r_mode != MODE_NONE) && (r_mode != MODE_XOR);
        if (is_crc) begin
            n_dig[0] = hex_char(n_crc[15:12]);
            n_dig[1] = hex_char(n_crc[11:8]);
            n_dig[2] = hex_char(n_crc[7:4]);
            n_dig[3] = hex_char(n_crc[3:0]);
        end else begin
            n_dig[0] = hex_char(n_crc[15:12]);
            n_dig[1] = hex_char(n_crc[11:8]);
            n_dig[2] = hex_char(n_xor[7:4]);
            n_dig[3] = hex_char(n_xor[3:0]);
        end
        acc_mask[SLOT_START] = !r_in_sentence;
        acc_mask[SLOT_DATA]  = 1'b1;
        acc_mask[SLOT_STAR]  = i_in_data.is_last;
        acc_mask[SLOT_D3]    = i_in_data.is_last && is_crc;
        acc_mask[SLOT_D2]    = i_in_data.is_last && is_crc;
        acc_mask[SLOT_D1]    = i_in_data.is_last && (r_mode != MODE_NONE);
        acc_mask[SLOT_D0]    = i_in_data.is_last && (r_mode != MODE_NONE);
        acc_mask[SLOT_NL]    = i_in_data.is_last;
    end

    always_comb begin
        n_mask = r_mask;
        if (out_acc) begin
            n_mask = r_mask & ~sel_bit;
        end
        if (in_acc) begin
            n_mask = acc_mask;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_RESET;
            r_in_sentence <= 1'b0;
            r_xor         <= 8'h00;
            r_crc         <= 16'h0000;
            r_mask        <= 8'h00;
        end else begin
            r_mask <= n_mask;
            if (i_cfg_we) begin
                r_mode <= i_cfg_data;
            end
            if (in_acc) begin
                if (i_in_data.is_last) begin
                    r_in_sentence <= 1'b0;
                    r_xor         <= 8'h00;
                    r_crc         <= 16'h0000;
                end else begin
                    r_in_sentence <= 1'b1;
                    r_xor         <= n_xor;
                    r_crc         <= n_crc;
                end
            end
        end
    end

    // Payload slots
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_byte <= i_in_data.data_byte;
            for (int k = 0; k < 4; k++) begin
                r_dig[k] <= n_dig[k];
            end
        end
    end

    // Checks
    `ASSERT_NEXT(a_acc_gives_beat, i_clk, i_rst_n, in_acc, o_out_valid,
        "accepted beat produced no output")
    `ASSERT_SAME(a_last_alone, i_clk, i_rst_n, o_out_valid && o_out_data.out_last,
        r_mask == 8'h80, "newline sent with characters still pending")
    `ASSERT_NEXT(a_last_closes, i_clk, i_rst_n, in_acc && i_in_data.is_last,
        !r_in_sentence && (r_xor == 8'h00) && (r_crc == 16'h0000),
        "sentence state not cleared after last character")

endmodule

`default_nettype wire

// File: sim/cmd_frm_checker.sv
// ----------------------------------------------------------------------------
// cmd_frm_checker
// Watches both channels of the command framer. It builds the expected
// sentence characters from every accepted input beat and compares each
// accepted output beat, field by field, against the oldest one waiting.
// ----------------------------------------------------------------------------
`default_nettype none

module cmd_frm_checker
    import cmd_frm_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_data,
    input  wire logic       i_in_valid,
    input  wire logic       i_in_stall,
    input  wire t_in_beat   i_in_data,
    input  wire logic       i_out_valid,
    input  wire logic       i_out_stall,
    input  wire t_out_beat  i_out_data,
    output int              o_fail_count,
    output int              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Mirror of the framer state
    logic [1:0]  cur_mode;
    logic        mid_sentence;
    logic [7:0]  xor_acc;
    logic [15:0] crc_acc;
    int          fail_n;

    // Sentence characters still owed by the framer, oldest first
    t_out_beat   sentence_q[$];

    // CRC-16-CCITT, MSB first, one bit per step
    function automatic logic [15:0] crc16_ccitt_byte(input logic [15:0] c,
                                                     input logic [7:0]  b);
        logic [15:0] r;
        r = c ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            r = r[15] ? ((r << 1) ^ 16'h1021) : (r << 1);
        end
        return r;
    endfunction

    // Upper-case ASCII for one nibble
    function automatic logic [7:0] nibble_ascii(input logic [3:0] n);
        logic [7:0] c;
        if (n < 4'd10) begin
            c = 8'h30 + {4'h0, n};
        end else begin
            c = 8'h41 + {4'h0, n} - 8'd10;
        end
        return c;
    endfunction

    always @(posedge i_clk) begin
        t_out_beat   want;
        logic [7:0]  ch;
        logic [7:0]  xor_new;
        logic [15:0] crc_new;
        if (!i_rst_n) begin
            cur_mode     = MODE_XOR;
            mid_sentence = 1'b0;
            xor_acc      = 8'h00;
            crc_acc      = 16'h0000;
            fail_n       = 0;
            sentence_q.delete();
        end else begin
            if (i_cfg_we) begin
                cur_mode = i_cfg_data;
            end

            // Output beat against the oldest expectation
            if (i_out_valid && !i_out_stall) begin
                if (sentence_q.size() == 0) begin
                    fail_n++;
                    $error("unexpected output beat: out_byte %h out_last %b",
                           i_out_data.out_byte, i_out_data.out_last);
                end else begin
                    want = sentence_q.pop_front();
                    if (i_out_data.out_byte !== want.out_byte) begin
                        fail_n++;
                        $error("out_byte: expected %h, actual %h",
                               want.out_byte, i_out_data.out_byte);
                    end
                    if (i_out_data.out_last !== want.out_last) begin
                        fail_n++;
                        $error("out_last: expected %b, actual %b",
                               want.out_last, i_out_data.out_last);
                    end
                end
            end

            // Input beat: queue the characters it frames
            if (i_in_valid && !i_in_stall) begin
                ch = i_in_data.data_byte;
                if (!mid_sentence) begin
                    sentence_q.push_back({CHAR_START, 1'b0});
                    mid_sentence = 1'b1;
                end
                sentence_q.push_back({ch, 1'b0});
                xor_new = xor_acc ^ ch;
                crc_new = crc16_ccitt_byte(crc_acc, ch);
                xor_acc = xor_new;
                crc_acc = crc_new;
                if (i_in_data.is_last) begin
                    sentence_q.push_back({CHAR_STAR, 1'b0});
                    if (cur_mode == MODE_XOR) begin
                        sentence_q.push_back({nibble_ascii(xor_acc[7:4]), 1'b0});
                        sentence_q.push_back({nibble_ascii(xor_acc[3:0]), 1'b0});
                    end else if (cur_mode >= MODE_CRC) begin
                        // mode 3 frames like CRC
                        sentence_q.push_back({nibble_ascii(crc_acc[15:12]), 1'b0});
                        sentence_q.push_back({nibble_ascii(crc_acc[11:8]), 1'b0});
                        sentence_q.push_back({nibble_ascii(crc_acc[7:4]), 1'b0});
                        sentence_q.push_back({nibble_ascii(crc_acc[3:0]), 1'b0});
                    end
                    sentence_q.push_back({CHAR_NL, 1'b1});
                    xor_acc      = 8'h00;
                    crc_acc      = 16'h0000;
                    mid_sentence = 1'b0;
                end
            end
        end
        o_fail_count <= fail_n;
        o_pending    <= sentence_q.size();
    end

endmodule

`default_nettype wire

// File: sim/tb_command_framer_with_checksum_core.sv
// ----------------------------------------------------------------------------
// tb_command_framer_with_checksum_core
// Drives command characters into the framer under all checksum modes, with
// random gaps on the sender and random stalls on the receiver; the checker
// beside the framer predicts every sentence character and counts mismatches.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_command_framer_with_checksum_core
    import cmd_frm_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] MODE_CRC_ALT = 2'd3;   // undefined code, framed as CRC
    localparam int         LONG_HOLD    = 200;
    localparam int         PHASE_BEATS  = 48;

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       i_cfg_we   = 1'b0;
    logic [1:0] i_cfg_data = MODE_NONE;
    logic       i_in_valid = 1'b0;
    t_in_beat   i_in_data  = '0;
    logic       i_out_stall = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    t_out_beat  o_out_data;

    int         fail_count;
    int         chars_owed;
    int         in_max_gap  = 0;
    int         out_max_gap = 0;
    bit         long_hold_req = 1'b0;

    command_framer_with_checksum_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    cmd_frm_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_data   (o_out_data),
        .o_fail_count (fail_count),
        .o_pending    (chars_owed)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Half the draws give no gap, the rest a random gap from zero up to max
    function automatic int draw_gap(input int max);
        if (max == 0) begin
            return 0;
        end
        return $urandom_range(0, 1) ? 0 : $urandom_range(0, max);
    endfunction

    // Mostly any non-zero byte, sometimes printable, rarely the extremes
    function automatic logic [7:0] pick_char();
        logic [7:0] c;
        case ($urandom_range(0, 15))
            0:       c = 8'h00;
            1:       c = 8'hFF;
            2, 3, 4: c = 8'($urandom_range(8'h20, 8'h7E));
            default: c = 8'($urandom_range(1, 255));
        endcase
        return c;
    endfunction

    // One command character; returns right after the beat is taken
    task automatic send_char(input logic [7:0] b, input logic l);
        int gap;
        gap = draw_gap(in_max_gap);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= {b, l};
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Random command of len characters, the last one flagged
    task automatic send_command(input int len);
        for (int k = 0; k < len; k++) begin
            send_char(pick_char(), k == len - 1);
        end
    endtask

    // Stop offering and wait until the framer has emitted everything
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (chars_owed != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic [1:0] m);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= m;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Receiver: random stall before each beat, one long hold on request
    initial begin
        int w;
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                w = LONG_HOLD;
            end else begin
                w = draw_gap(out_max_gap);
            end
            if (w > 0) begin
                i_out_stall <= 1'b1;
                repeat (w) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
        end
    end

    // Stimulus and verdict
    initial begin
        logic [1:0] phase_mode [6];
        int         phase_in   [6];
        int         phase_out  [6];
        int         sent;
        int         len;

        phase_mode = '{MODE_CRC, MODE_NONE, MODE_XOR, MODE_CRC_ALT, MODE_CRC, MODE_XOR};
        phase_in   = '{0, 12, 0, 12, 12, 3};
        phase_out  = '{0, 12, 12, 0, 12, 3};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset mode is XOR
        send_char(8'h01, 1'b1);
        send_char(8'hFF, 1'b1);
        send_char("A", 1'b0);
        send_char("B", 1'b1);

        // No checksum, zero character passed through
        write_mode(MODE_NONE);
        send_char(8'h80, 1'b1);
        send_char(8'h7F, 1'b0);
        send_char(8'h00, 1'b1);

        // CRC on a short string and on repeated all-ones
        in_max_gap  = 12;
        out_max_gap = 12;
        write_mode(MODE_CRC);
        send_char("1", 1'b0);
        send_char("2", 1'b0);
        send_char("3", 1'b0);
        send_char("4", 1'b1);
        send_char(8'h55, 1'b0);
        send_char(8'hAA, 1'b1);
        send_char(8'hFF, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(8'hFF, 1'b1);

        // Code 3 frames as CRC
        write_mode(MODE_CRC_ALT);
        send_char(8'h01, 1'b1);
        send_char(8'h5A, 1'b0);
        send_char(8'hA5, 1'b1);

        // Random phases, one per mode setting and idling profile
        for (int p = 0; p < 6; p++) begin
            write_mode(phase_mode[p]);
            in_max_gap  = phase_in[p];
            out_max_gap = phase_out[p];
            if (p == 2) begin
                // receiver holds off while the sender keeps offering
                long_hold_req = 1'b1;
            end
            sent = 0;
            while (sent < PHASE_BEATS) begin
                len = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(1, 12);
                send_command(len);
                sent += len;
            end
        end

        // Let the last sentence finish, then a short tail
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (chars_owed != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Run limit
    initial begin
        #5ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
+incdir+hdl
hdl/cmd_frm_pkg.sv
hdl/command_framer_with_checksum_core.sv
sim/cmd_frm_checker.sv
sim/tb_command_framer_with_checksum_core.sv
